@@ rtl/core/mm256_pkg.sv @@
// Shared types and constants for the 256-bit Montgomery multiplier.
package mm256_pkg;

  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = 4;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W          = 3;
  localparam logic [2:0] CFG_MOD0   = 3'd0;
  localparam logic [2:0] CFG_MOD1   = 3'd1;
  localparam logic [2:0] CFG_MOD2   = 3'd2;
  localparam logic [2:0] CFG_MOD3   = 3'd3;
  localparam logic [2:0] CFG_NINV   = 3'd4;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word4_t;

  // operand pair as it travels on in_tdata: a in the low half
  typedef struct packed {
    word4_t b;
    word4_t a;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic start;
    logic finishing;
  } eng_stat_t;

endpackage

@@ rtl/core/mm256_queue.sv @@
// Front queue: accepts operand items and holds them for the engine.
module mm256_queue #(
  parameter int DEPTH = mm256_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mm256_pkg::item_t   in_item,
  output logic               q_valid,
  input  logic               q_ready,
  output mm256_pkg::item_t   q_item,
  output mm256_pkg::q_stat_t q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mm256_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_ready      = (cnt_r != CW'(DEPTH));
  assign q_valid       = (cnt_r != '0);
  assign q_item        = mem_r[rd_ptr_r];
  assign push          = in_valid && in_ready;
  assign pop           = q_valid && q_ready;
  assign q_stat.empty  = (cnt_r == '0);
  assign q_stat.full   = !in_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

@@ rtl/core/mm256_mac.sv @@
// 64x64 multiply-add (acc + x*y + cin) built from four 32x32 partial products.
module mm256_mac (
  input  logic        clk,
  input  logic [1:0]  step,
  input  logic [63:0] x,
  input  logic [63:0] y,
  input  logic [63:0] acc,
  input  logic [63:0] cin,
  output logic [63:0] lo,
  output logic [63:0] hi
);

  logic [127:0] prod_r, prod_nxt;
  logic [127:0] base;
  logic [127:0] shifted;
  logic [31:0]  xs, ys;
  logic [63:0]  pp;

  always_comb begin
    xs = step[1] ? x[63:32] : x[31:0];
    ys = step[0] ? y[63:32] : y[31:0];
    pp = {32'd0, xs} * {32'd0, ys};
    case (step)
      2'd0:    shifted = {64'd0, pp};
      2'd3:    shifted = {pp, 64'd0};
      default: shifted = {32'd0, pp, 32'd0};
    endcase
    // step 0 seeds the sum with acc + cin; the total never exceeds 128 bits
    base     = (step == 2'd0) ? ({64'd0, acc} + {64'd0, cin}) : prod_r;
    prod_nxt = base + shifted;
  end

  assign lo = prod_nxt[63:0];
  assign hi = prod_nxt[127:64];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

@@ rtl/core/mm256_engine.sv @@
// Back engine: CIOS rounds sequenced over one shared multiply-add unit.
module mm256_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  mm256_pkg::item_t     q_item,
  input  mm256_pkg::word4_t    modulus,
  input  logic [63:0]          ninv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mm256_pkg::word4_t    out_data,
  output mm256_pkg::eng_stat_t eng_stat
);

  mm256_pkg::eng_state_t st_r, st_nxt;
  mm256_pkg::word4_t     a_r, b_r, t_r;
  mm256_pkg::word4_t     out_data_r;
  logic                  out_valid_r;
  logic [1:0]            round_r;
  logic [3:0]            op_r;
  logic [1:0]            step_r;
  logic [63:0]           pc_r, rc_r, k_r, x_r;
  logic [63:0]           mx, my, macc, mcin, lo, hi;
  logic [63:0]           ai;
  logic [3:0]            op_m2;
  logic [1:0]            jo, je;
  logic                  op_done, item_last, load_out, running;

  assign ai        = a_r[round_r];
  assign op_m2     = op_r - 4'd2;
  assign jo        = op_r[2:1];
  assign je        = op_m2[2:1];
  assign op_done   = (step_r == 2'd3);
  assign item_last = op_done && (op_r == 4'd8) && (round_r == 2'd3);

  // operand select per op of a round
  always_comb begin
    mx   = ai;
    my   = b_r[0];
    macc = t_r[0];
    mcin = '0;
    case (op_r)
      4'd0: begin
        mx = ai; my = b_r[0]; macc = t_r[0]; mcin = '0;
      end
      4'd1: begin
        mx = t_r[0]; my = ninv; macc = '0; mcin = '0;
      end
      4'd2: begin
        mx = k_r; my = modulus[0]; macc = t_r[0]; mcin = '0;
      end
      4'd3, 4'd5, 4'd7: begin
        mx = ai; my = b_r[jo]; macc = t_r[jo]; mcin = pc_r;
      end
      default: begin
        mx = k_r; my = modulus[je]; macc = x_r; mcin = rc_r;
      end
    endcase
  end

  mm256_mac u_mac (
    .clk  (clk),
    .step (step_r),
    .x    (mx),
    .y    (my),
    .acc  (macc),
    .cin  (mcin),
    .lo   (lo),
    .hi   (hi)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mm256_pkg::ST_IDLE: if (q_valid) st_nxt = mm256_pkg::ST_RUN;
      mm256_pkg::ST_RUN:  if (item_last) st_nxt = mm256_pkg::ST_DONE;
      mm256_pkg::ST_DONE: if (!out_valid_r || out_ready) st_nxt = mm256_pkg::ST_IDLE;
      default:            st_nxt = mm256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    load_out = 1'b0;
    running  = 1'b0;
    unique case (st_r)
      mm256_pkg::ST_IDLE: q_ready  = 1'b1;
      mm256_pkg::ST_RUN:  running  = 1'b1;
      mm256_pkg::ST_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mm256_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      op_r        <= '0;
      step_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (running) begin
        step_r <= step_r + 1'b1;
        if (op_done) begin
          if (op_r == 4'd8) begin
            op_r    <= '0;
            round_r <= round_r + 1'b1;
          end else begin
            op_r <= op_r + 1'b1;
          end
        end
      end else begin
        step_r  <= '0;
        op_r    <= '0;
        round_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      a_r  <= q_item.a;
      b_r  <= q_item.b;
      t_r  <= '0;
      pc_r <= '0;
      rc_r <= '0;
    end else if (running && op_done) begin
      case (op_r)
        4'd0: begin
          t_r[0] <= lo;
          pc_r   <= hi;
        end
        4'd1: k_r  <= lo;
        4'd2: rc_r <= hi;
        4'd3, 4'd5, 4'd7: begin
          x_r  <= lo;
          pc_r <= hi;
        end
        default: begin
          t_r[je - 2'd1] <= lo;
          rc_r           <= hi;
          // top word of the round; carry out of it is dropped
          if (op_r == 4'd8) t_r[3] <= hi + pc_r;
        end
      endcase
    end
    if (load_out) begin
      out_data_r <= t_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign eng_stat.start     = q_valid && q_ready;
  assign eng_stat.finishing = load_out;

endmodule

@@ rtl/core/montgomery_multiply_256_top.sv @@
// Top level of the 256-bit CIOS Montgomery multiplier (no final subtraction).
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | in_tdata[511:0]: a_word0..3, b_word0..3
// out_    | out | out_tvalid/tready  | out_tdata[255:0]: prod_word0..3
// cfg_    | in  | cfg_valid/ready    | cfg_index[2:0], cfg_data[63:0]
//
// Each item runs 36 multiply-adds (4 rounds x 9) in turn through one 64x64 multiply-add
// unit; the engine picks up an item, runs its rounds, then hands off the result, and
// takes no new item until the hand-off.
// A 2-entry input queue takes items while the engine works and while a result
// waits in the output register; out stalls never block input until the queue fills.
// rst_n is synchronous, active low; moduli and inverse reset to zero.
// cfg writes are always taken; indexes above 4 are ignored.
module montgomery_multiply_256_top #(
  parameter int QDEPTH = mm256_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // a_word0, a_word1, a_word2, a_word3, b_word0, b_word1, b_word2, b_word3
  input  logic [511:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // prod_word0, prod_word1, prod_word2, prod_word3
  output logic [255:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  mm256_pkg::word4_t    modulus_r;
  logic [63:0]          ninv_r;
  mm256_pkg::item_t     q_item;
  mm256_pkg::word4_t    out_data;
  mm256_pkg::q_stat_t   q_stat;
  mm256_pkg::eng_stat_t eng_stat;
  logic                 q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
      ninv_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mm256_pkg::CFG_MOD0: modulus_r[0] <= cfg_data;
        mm256_pkg::CFG_MOD1: modulus_r[1] <= cfg_data;
        mm256_pkg::CFG_MOD2: modulus_r[2] <= cfg_data;
        mm256_pkg::CFG_MOD3: modulus_r[3] <= cfg_data;
        mm256_pkg::CFG_NINV: ninv_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  mm256_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (mm256_pkg::item_t'(in_tdata)),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .q_stat   (q_stat)
  );

  mm256_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .modulus   (modulus_r),
    .ninv      (ninv_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .eng_stat  (eng_stat)
  );

  assign out_tdata = out_data;

`ifndef ASSERT_OFF
  // a fresh result only appears right after the engine hands one off
  a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(eng_stat.finishing))
    else $error("result appeared without engine hand-off");

  // engine only starts on a queued item
  a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.start |-> !q_stat.empty)
    else $error("engine started from empty queue");

  // an accepted item not taken straight away stays queued
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !eng_stat.start) |=> !q_stat.empty)
    else $error("accepted item lost from queue");
`endif

endmodule

@@ tb/sv/montgomery_multiply_256_checker.sv @@
// Checker for the Montgomery multiplier: predicts each product and compares results.
module montgomery_multiply_256_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [511:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [255:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending_count
);

  mm256_pkg::word4_t modulus;
  logic [63:0]       ninv;
  mm256_pkg::word4_t expected_products[$];
  int                mismatches;

  // CIOS product, no final subtraction, top carry wrapped
  function automatic mm256_pkg::word4_t mont_product(mm256_pkg::word4_t a,
                                                     mm256_pkg::word4_t b,
                                                     mm256_pkg::word4_t p,
                                                     logic [63:0] q);
    logic [63:0]       t [mm256_pkg::NUM_WORDS];
    logic [127:0]      acc;
    logic [63:0]       pc, rc, k, x;
    mm256_pkg::word4_t r;
    for (int j = 0; j < mm256_pkg::NUM_WORDS; j++) t[j] = '0;
    for (int i = 0; i < mm256_pkg::NUM_WORDS; i++) begin
      acc = 128'(a[i]) * 128'(b[0]) + 128'(t[0]);
      t[0] = acc[63:0];
      pc = acc[127:64];
      k = t[0] * q;
      acc = 128'(k) * 128'(p[0]) + 128'(t[0]);
      rc = acc[127:64];
      for (int j = 1; j < mm256_pkg::NUM_WORDS; j++) begin
        acc = 128'(a[i]) * 128'(b[j]) + 128'(t[j]) + 128'(pc);
        x = acc[63:0];
        pc = acc[127:64];
        acc = 128'(k) * 128'(p[j]) + 128'(x) + 128'(rc);
        t[j-1] = acc[63:0];
        rc = acc[127:64];
      end
      t[mm256_pkg::NUM_WORDS-1] = rc + pc;
    end
    for (int j = 0; j < mm256_pkg::NUM_WORDS; j++) r[j] = t[j];
    return r;
  endfunction

  assign pending_count = expected_products.size();

  always @(posedge clk) begin
    mm256_pkg::item_t  op;
    mm256_pkg::word4_t got, want;
    if (!rst_n) begin
      modulus <= '0;
      ninv <= '0;
      expected_products.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        op = in_tdata;
        expected_products.push_back(mont_product(op.a, op.b, modulus, ninv));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_products.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_products.pop_front();
          for (int j = 0; j < mm256_pkg::NUM_WORDS; j++)
            if (got[j] !== want[j]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("prod_word%0d: expected %h, got %h", j, want[j], got[j]);
            end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mm256_pkg::CFG_MOD0: modulus[0] <= cfg_data;
          mm256_pkg::CFG_MOD1: modulus[1] <= cfg_data;
          mm256_pkg::CFG_MOD2: modulus[2] <= cfg_data;
          mm256_pkg::CFG_MOD3: modulus[3] <= cfg_data;
          mm256_pkg::CFG_NINV: ninv <= cfg_data;
          default: ;
        endcase
      end
      fail_count <= mismatches;
    end
  end
endmodule

@@ tb/sv/montgomery_multiply_256_top_tb.sv @@
// Testbench top for the Montgomery multiplier: stimulus, configuration and verdict.
module montgomery_multiply_256_top_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [511:0] in_tdata;   // a_word0..3, b_word0..3
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;  // prod_word0..3
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;
  int           fail_count;
  int           pending_count;

  // idle rates in percent for each side; out_hold forces a long receiver stall
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  out_hold;

  montgomery_multiply_256_top i_dut (.*);

  montgomery_multiply_256_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // generous limit: ~500 items, stalls several times over
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random ready, or held low while out_hold is set
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      out_tready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // a 64-bit word biased toward the edges of its range
  function automatic logic [63:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // leaves in_tvalid high after the accepting edge; the next call drops it or offers its own item, drain drops it
  task automatic send_item(mm256_pkg::word4_t a, mm256_pkg::word4_t b);
    mm256_pkg::item_t op;
    op.a = a;
    op.b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // leaves cfg_valid high; load_modulus drops it after its last write
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // drain all results, then allow the engine's latency before touching registers
  task automatic drain();
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // modulus with its -p^-1 mod 2^64; wrong_inv leaves the inverse off by random bits
  task automatic load_modulus(mm256_pkg::word4_t p, bit wrong_inv);
    logic [63:0] inv;
    inv = 1;
    for (int n = 0; n < 6; n++) inv = inv * (64'd2 - p[0] * inv);
    inv = -inv;
    if (wrong_inv) inv = inv ^ {$urandom, $urandom};
    write_reg(mm256_pkg::CFG_MOD0, p[0]);
    write_reg(mm256_pkg::CFG_MOD1, p[1]);
    write_reg(mm256_pkg::CFG_MOD2, p[2]);
    write_reg(mm256_pkg::CFG_MOD3, p[3]);
    write_reg(mm256_pkg::CFG_NINV, inv);
    // out-of-range index must be ignored
    write_reg(3'd5 + 3'($urandom_range(2)), {$urandom, $urandom});
    cfg_valid <= 0;
  endtask

  task automatic random_operands(output mm256_pkg::word4_t a,
                                 output mm256_pkg::word4_t b);
    for (int j = 0; j < mm256_pkg::NUM_WORDS; j++) begin
      a[j] = pick_word();
      b[j] = pick_word();
    end
  endtask

  initial begin
    mm256_pkg::word4_t a, b, p;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 34;
    recv_idle_pct = 69;
    out_hold = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset registers: p = 0, inverse 0
    send_item('1, '1);
    drain();

    // a typical odd 256-bit modulus
    p = {64'h30644e72e131a029, 64'hb85045b68181585d,
         64'h97816a916871ca8d, 64'h3c208c16d87cfd47};
    load_modulus(p, 0);
    send_item('0, '0);
    send_item('1, '1);
    send_item(mm256_pkg::word4_t'(1), '1);
    send_item('1, mm256_pkg::word4_t'(1));
    send_item({64'h8000000000000000, 192'h0}, mm256_pkg::word4_t'(2));
    send_item(p, p);
    send_item(p, mm256_pkg::word4_t'(1));
    drain();

    // all-ones modulus (largest), then p = 1 (smallest odd)
    load_modulus('1, 0);
    send_item('1, '1);
    send_item({64'h1, 64'h0, 64'h0, 64'h0}, '1);
    drain();
    load_modulus(mm256_pkg::word4_t'(1), 0);
    send_item('1, '1);
    send_item({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom}, '1);
    drain();

    // even modulus and wrong inverse
    load_modulus({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 32'($urandom) & ~32'h1}, 0);
    send_item('1, '1);
    send_item({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom}, '1);
    drain();
    load_modulus(p, 1);
    send_item('1, '1);
    send_item({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom}, p);

    // long receiver stall while the sender keeps offering items
    drain();
    out_hold = 1;
    fork
      begin
        repeat (1200) @(posedge clk);
        out_hold = 0;
      end
      for (int n = 0; n < 5; n++) begin
        random_operands(a, b);
        send_item(a, b);
      end
    join
    drain();

    // random phases: receiver idles more, then sender, then neither
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 34 : 0;
      for (int w = 0; w < mm256_pkg::NUM_WORDS; w++) p[w] = pick_word();
      p[0][0] = 1'b1;
      load_modulus(p, ($urandom_range(9) == 0));
      for (int n = 0; n < 160; n++) begin
        random_operands(a, b);
        send_item(a, b);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ montgomery_multiply_256_top.f @@
rtl/core/mm256_pkg.sv
rtl/core/mm256_queue.sv
rtl/core/mm256_mac.sv
rtl/core/mm256_engine.sv
rtl/core/montgomery_multiply_256_top.sv
tb/sv/montgomery_multiply_256_checker.sv
tb/sv/montgomery_multiply_256_top_tb.sv
